FILE: hdl/dtt_pkg.sv
// package for the dual timer / time-of-day / key matrix peripheral
// types, register offsets, command codes and bit constants; no dependencies
package dtt_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_KEY   = 2'd3;

  localparam logic [3:0] REG_PRA   = 4'd0;
  localparam logic [3:0] REG_PRB   = 4'd1;
  localparam logic [3:0] REG_DIR_A = 4'd2;
  localparam logic [3:0] REG_DIR_B = 4'd3;
  localparam logic [3:0] REG_TA_LO = 4'd4;
  localparam logic [3:0] REG_TA_HI = 4'd5;
  localparam logic [3:0] REG_TB_LO = 4'd6;
  localparam logic [3:0] REG_TB_HI = 4'd7;
  localparam logic [3:0] REG_TOD10 = 4'd8;
  localparam logic [3:0] REG_TODS  = 4'd9;
  localparam logic [3:0] REG_TODM  = 4'd10;
  localparam logic [3:0] REG_TODH  = 4'd11;
  localparam logic [3:0] REG_SDR   = 4'd12;
  localparam logic [3:0] REG_ICR   = 4'd13;
  localparam logic [3:0] REG_CRA   = 4'd14;
  localparam logic [3:0] REG_CRB   = 4'd15;

  localparam logic [19:0] TOD_PERIOD_RST = 20'd98525;
  localparam logic [7:0]  SECMIN_MAX     = 8'h59;
  localparam logic [7:0]  HOUR_MAX       = 8'h12;
  localparam logic [7:0]  HOUR_PM_FLIP   = 8'h11;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
    logic [2:0] key_column;
    logic [2:0] key_row;
    logic       key_down;
    logic [1:0] port_a_pins_in;
  } dtt_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_raised;
    logic       irq_pending;
  } dtt_out_t;

  typedef struct packed {
    logic [7:0] tenths;
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hr;
  } dtt_tod_t;

  // one bcd increment with ceiling, as the counter chain uses it
  function automatic logic [7:0] bcd_step(input logic [7:0] v, input logic [7:0] ceil);
    logic [4:0] lo;
    logic [4:0] hi;
    logic [7:0] r;
    lo = {1'b0, v[3:0]} + 5'd1;
    hi = {1'b0, v[7:4]};
    if (lo > 5'd9) begin
      lo = 5'd0;
      hi = hi + 5'd1;
    end
    r = {hi[3:0], lo[3:0]};
    return (r > ceil) ? 8'h00 : r;
  endfunction

endpackage

FILE: hdl/dual_timer_tod_io_peripheral.sv
// Each accepted item's result is registered directly in the output register.
// Throughput: one item per cycle unless the output stalls; the input feeds all
// state updates and the result register in a single pass of combinational logic.
// Reset (rst_n low, synchronous): all registers but result data to documented
// reset values, output empty; configuration takes effect on the following item.
// top level: uses dtt_pkg
module dual_timer_tod_io_peripheral (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dtt_pkg::dtt_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dtt_pkg::dtt_out_t    out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [19:0]          cfg_data
);

  logic [19:0] period_r;
  logic [7:0]  pa_r, pb_r, ddra_r, ddrb_r, cra_r, crb_r, sdr_r, flags_r;
  logic [4:0]  mask_r;
  logic [7:0]  km_r [8];
  logic [15:0] tal_r, tac_r, tbl_r, tbc_r;
  dtt_pkg::dtt_tod_t tod_r, alarm_r, snap_r;
  logic        held_r;
  logic [19:0] div_r;
  logic        ov_r;
  dtt_pkg::dtt_out_t od_r;

  logic [7:0]  pa_nxt, pb_nxt, ddra_nxt, ddrb_nxt, cra_nxt, crb_nxt, sdr_nxt, flags_nxt;
  logic [4:0]  mask_nxt;
  logic [15:0] tal_nxt, tac_nxt, tbl_nxt, tbc_nxt;
  dtt_pkg::dtt_tod_t tod_nxt, alarm_nxt, snap_nxt, tod_adv;
  logic        held_nxt;
  logic [19:0] div_nxt, div_inc;
  logic [7:0]  rd, pbv, ns, nm, nh, ext;
  logic        fired, a_under, b_step;
  logic [7:0]  src;
  logic        accept;
  dtt_pkg::dtt_in_t it;

  assign it        = in_data;
  assign in_ready  = !ov_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // port b view of the key matrix
  always_comb begin
    pbv = 8'hFF;
    for (int c = 0; c < 8; c++) begin
      if (!pa_r[c]) pbv = pbv & km_r[c];
    end
  end

  // next time-of-day value after one tenth advance
  always_comb begin
    tod_adv = tod_r;
    ns = dtt_pkg::bcd_step(tod_r.sec, dtt_pkg::SECMIN_MAX);
    nm = dtt_pkg::bcd_step(tod_r.min, dtt_pkg::SECMIN_MAX);
    nh = dtt_pkg::bcd_step({3'b000, tod_r.hr[4:0]}, dtt_pkg::HOUR_MAX);
    if (nh == 8'h00) nh = 8'h01;
    if ({4'h0, tod_r.tenths[3:0]} < 8'h09) begin
      tod_adv.tenths = {4'h0, tod_r.tenths[3:0] + 4'd1};
    end else begin
      tod_adv.tenths = 8'h00;
      if (ns == 8'h00 && tod_r.sec == dtt_pkg::SECMIN_MAX) begin
        tod_adv.sec = 8'h00;
        if (nm == 8'h00 && tod_r.min == dtt_pkg::SECMIN_MAX) begin
          tod_adv.min = 8'h00;
          tod_adv.hr  = {tod_r.hr[7] ^ ({3'b000, tod_r.hr[4:0]} == dtt_pkg::HOUR_PM_FLIP),
                         2'b00, nh[4:0]};
        end else begin
          tod_adv.min = nm;
        end
      end else begin
        tod_adv.sec = ns;
      end
    end
  end

  // command execution
  always_comb begin
    pa_nxt = pa_r; pb_nxt = pb_r; ddra_nxt = ddra_r; ddrb_nxt = ddrb_r;
    cra_nxt = cra_r; crb_nxt = crb_r; sdr_nxt = sdr_r; mask_nxt = mask_r;
    tal_nxt = tal_r; tac_nxt = tac_r; tbl_nxt = tbl_r; tbc_nxt = tbc_r;
    tod_nxt = tod_r; alarm_nxt = alarm_r; snap_nxt = snap_r; held_nxt = held_r;
    div_nxt = div_r; rd = 8'h00; src = 8'h00;
    a_under = 1'b0; b_step = 1'b0;
    div_inc = div_r + 20'd1;
    ext = {it.port_a_pins_in, 6'b000000};
    unique case (it.command)
      dtt_pkg::CMD_TICK: begin
        // timer a
        if (cra_r[0]) begin
          if (tac_r == 16'h0000) begin
            tac_nxt = tal_r;
            if (cra_r[3]) cra_nxt[0] = 1'b0;
            src[0] = 1'b1;
            a_under = 1'b1;
          end else begin
            tac_nxt = tac_r - 16'd1;
          end
        end
        // timer b from ticks or timer a underflow
        b_step = crb_r[0] && (crb_r[6] ? a_under : 1'b1);
        if (b_step) begin
          if (tbc_r == 16'h0000) begin
            tbc_nxt = tbl_r;
            if (crb_r[3]) crb_nxt[0] = 1'b0;
            src[1] = 1'b1;
          end else begin
            tbc_nxt = tbc_r - 16'd1;
          end
        end
        // tod divider and alarm compare
        if (div_inc >= period_r) begin
          div_nxt = 20'd0;
          tod_nxt = tod_adv;
          if (tod_adv.tenths[3:0] == alarm_r.tenths[3:0] && tod_adv.sec == alarm_r.sec &&
              tod_adv.min == alarm_r.min &&
              (tod_adv.hr & 8'h9F) == (alarm_r.hr & 8'h9F)) src[2] = 1'b1;
        end else begin
          div_nxt = div_inc;
        end
      end
      dtt_pkg::CMD_READ: begin
        unique case (it.reg_offset)
          dtt_pkg::REG_PRA:   rd = (pa_r & ddra_r) | (ext & ~ddra_r);
          dtt_pkg::REG_PRB:   rd = pbv;
          dtt_pkg::REG_DIR_A: rd = ddra_r;
          dtt_pkg::REG_DIR_B: rd = ddrb_r;
          dtt_pkg::REG_TA_LO: rd = tac_r[7:0];
          dtt_pkg::REG_TA_HI: rd = tac_r[15:8];
          dtt_pkg::REG_TB_LO: rd = tbc_r[7:0];
          dtt_pkg::REG_TB_HI: rd = tbc_r[15:8];
          dtt_pkg::REG_TOD10: begin
            rd = held_r ? snap_r.tenths : tod_r.tenths;
            held_nxt = 1'b0;
          end
          dtt_pkg::REG_TODS: rd = held_r ? snap_r.sec : tod_r.sec;
          dtt_pkg::REG_TODM: rd = held_r ? snap_r.min : tod_r.min;
          dtt_pkg::REG_TODH: begin
            rd = tod_r.hr;
            snap_nxt = tod_r;
            held_nxt = 1'b1;
          end
          dtt_pkg::REG_SDR:  rd = sdr_r;
          dtt_pkg::REG_ICR:  rd = flags_r;
          dtt_pkg::REG_CRA:  rd = cra_r;
          dtt_pkg::REG_CRB:  rd = {1'b0, crb_r[6:0]};
          default:           rd = 8'h00;
        endcase
      end
      dtt_pkg::CMD_WRITE: begin
        unique case (it.reg_offset)
          dtt_pkg::REG_PRA:   pa_nxt = it.write_data;
          dtt_pkg::REG_PRB:   pb_nxt = it.write_data;
          dtt_pkg::REG_DIR_A: ddra_nxt = it.write_data;
          dtt_pkg::REG_DIR_B: ddrb_nxt = it.write_data;
          dtt_pkg::REG_TA_LO: tal_nxt = {tal_r[15:8], it.write_data};
          dtt_pkg::REG_TA_HI: begin
            tal_nxt = {it.write_data, tal_r[7:0]};
            if (!cra_r[0]) tac_nxt = {it.write_data, tal_r[7:0]};
          end
          dtt_pkg::REG_TB_LO: tbl_nxt = {tbl_r[15:8], it.write_data};
          dtt_pkg::REG_TB_HI: begin
            tbl_nxt = {it.write_data, tbl_r[7:0]};
            if (!crb_r[0]) tbc_nxt = {it.write_data, tbl_r[7:0]};
          end
          dtt_pkg::REG_TOD10: begin
            if (crb_r[7]) alarm_nxt.tenths = {4'h0, it.write_data[3:0]};
            else tod_nxt.tenths = {4'h0, it.write_data[3:0]};
          end
          dtt_pkg::REG_TODS: begin
            if (crb_r[7]) alarm_nxt.sec = it.write_data & 8'h7F;
            else tod_nxt.sec = it.write_data & 8'h7F;
          end
          dtt_pkg::REG_TODM: begin
            if (crb_r[7]) alarm_nxt.min = it.write_data & 8'h7F;
            else tod_nxt.min = it.write_data & 8'h7F;
          end
          dtt_pkg::REG_TODH: begin
            if (crb_r[7]) alarm_nxt.hr = it.write_data & 8'h9F;
            else tod_nxt.hr = it.write_data & 8'h9F;
          end
          dtt_pkg::REG_SDR:  sdr_nxt = it.write_data;
          dtt_pkg::REG_ICR: begin
            if (it.write_data[7]) mask_nxt = mask_r | it.write_data[4:0];
            else mask_nxt = mask_r & ~it.write_data[4:0];
          end
          dtt_pkg::REG_CRA: begin
            cra_nxt = {it.write_data[7:5], 1'b0, it.write_data[3:0]};
            if (it.write_data[4]) tac_nxt = tal_r;
          end
          dtt_pkg::REG_CRB: begin
            crb_nxt = {it.write_data[7:5], 1'b0, it.write_data[3:0]};
            if (it.write_data[4]) tbc_nxt = tbl_r;
          end
          default: ;
        endcase
      end
      dtt_pkg::CMD_KEY: ;
      default: ;
    endcase
    // interrupt flags
    fired = |(src[4:0] & mask_r);
    if (it.command == dtt_pkg::CMD_READ && it.reg_offset == dtt_pkg::REG_ICR)
      flags_nxt = 8'h00;
    else
      flags_nxt = flags_r | src | {fired, 7'b0000000};
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= dtt_pkg::TOD_PERIOD_RST;
      pa_r <= 8'hFF; pb_r <= 8'hFF; ddra_r <= 8'h00; ddrb_r <= 8'h00;
      cra_r <= 8'h00; crb_r <= 8'h00; sdr_r <= 8'h00; flags_r <= 8'h00; mask_r <= 5'd0;
      tal_r <= 16'hFFFF; tac_r <= 16'hFFFF; tbl_r <= 16'hFFFF; tbc_r <= 16'hFFFF;
      tod_r <= '{8'h00, 8'h00, 8'h00, 8'h01};
      alarm_r <= '0;
      snap_r <= '{8'h00, 8'h00, 8'h00, 8'h01};
      held_r <= 1'b0; div_r <= 20'd0; ov_r <= 1'b0;
      for (int c = 0; c < 8; c++) km_r[c] <= 8'hFF;
    end else begin
      if (cfg_valid) period_r <= cfg_data;
      if (accept) begin
        pa_r <= pa_nxt; pb_r <= pb_nxt; ddra_r <= ddra_nxt; ddrb_r <= ddrb_nxt;
        cra_r <= cra_nxt; crb_r <= crb_nxt; sdr_r <= sdr_nxt; flags_r <= flags_nxt;
        mask_r <= mask_nxt; tal_r <= tal_nxt; tac_r <= tac_nxt; tbl_r <= tbl_nxt;
        tbc_r <= tbc_nxt; tod_r <= tod_nxt; alarm_r <= alarm_nxt; snap_r <= snap_nxt;
        held_r <= held_nxt; div_r <= div_nxt;
        if (it.command == dtt_pkg::CMD_KEY) km_r[it.key_column][it.key_row] <= !it.key_down;
      end
      if (accept) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      od_r.read_data   <= rd;
      od_r.irq_raised  <= fired;
      od_r.irq_pending <= flags_nxt[7];
    end
  end

endmodule

FILE: hdl/dtt_checker.sv
// port-level checker for dual_timer_tod_io_peripheral, bound to the top level
// depends on dtt_pkg for the payload types
module dtt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input dtt_pkg::dtt_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input dtt_pkg::dtt_out_t out_data
);

  // a result stalls unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // every accepted item gives a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("missing result");

  // reads of nothing: non-read commands return zero
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command != dtt_pkg::CMD_READ |=>
    out_data.read_data == 8'h00)
    else $error("non-read gave data");

  // a raised interrupt always leaves the summary bit set
  a_raise_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.irq_raised |-> out_data.irq_pending)
    else $error("raised without pending");

  // input never blocked while output is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("stall without cause");

endmodule

bind dual_timer_tod_io_peripheral dtt_checker u_dtt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
